// File: rtl/mdf_pkg.sv
// ----------------------------------------------------------------------------
// mdf_pkg: shared types and constants of the modulated delay flanger
// Frame and result payloads, the register map, the multiply-accumulate
// request, the saturation helper and the delay RAM address helper.
// ----------------------------------------------------------------------------
package mdf_pkg;

  localparam int DELAY_LENGTH = 1024;
  localparam int CHANNELS     = 2;

  localparam int AW        = $clog2(DELAY_LENGTH);
  localparam int MEM_DEPTH = CHANNELS * DELAY_LENGTH;
  localparam int MEM_AW    = $clog2(MEM_DEPTH);

  // delay word, Q8 samples, signed, wide enough for every sum and bound
  localparam int DW        = 27;
  localparam int DELAY_MIN = 26;
  localparam int DELAY_MAX = (DELAY_LENGTH - 2) * 256;

  localparam int CFG_DW    = 18;
  localparam int CFG_IW    = 3;

  localparam int MAC_AW    = 16;
  localparam int MAC_BW    = 19;
  localparam int PROD_W    = MAC_AW + MAC_BW;
  localparam int ACC_W     = 36;
  localparam int BIAS_W    = 15;

  localparam logic [BIAS_W-1:0] BIAS_NONE = BIAS_W'(0);
  localparam logic [BIAS_W-1:0] BIAS_Q8   = BIAS_W'(128);
  localparam logic [BIAS_W-1:0] BIAS_Q15  = BIAS_W'(16384);

  typedef enum logic [CFG_IW-1:0] {
    REG_CENTRE_DELAY    = 3'd0,
    REG_SWEEP_DEPTH     = 3'd1,
    REG_FEEDBACK_GAIN   = 3'd2,
    REG_WET_MIX         = 3'd3,
    REG_ACTIVE_CHANNELS = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic        [17:0] centre_delay;
    logic        [17:0] sweep_depth;
    logic signed [15:0] feedback_gain;
    logic        [15:0] wet_mix;
    logic        [1:0]  active_channels;
  } cfg_t;

  typedef struct packed {
    logic signed [15:0] modulator_value;
    logic signed [15:0] sample_left;
    logic signed [15:0] sample_right;
  } frame_t;

  typedef struct packed {
    logic signed [15:0] out_left;
    logic signed [15:0] out_right;
  } result_t;

  // one request to the shared multiply-accumulate unit
  typedef struct packed {
    logic                     en;
    logic                     load;
    logic [BIAS_W-1:0]        bias;
    logic signed [MAC_AW-1:0] a;
    logic signed [MAC_BW-1:0] b;
  } mac_op_t;

  function automatic logic signed [15:0] sat16(input logic signed [20:0] v);
    logic signed [15:0] r;
    if (v > 21'sd32767) begin
      r = 16'sd32767;
    end else if (v < -21'sd32768) begin
      r = -16'sd32768;
    end else begin
      r = v[15:0];
    end
    return r;
  endfunction

  function automatic logic [MEM_AW-1:0] mem_addr(input logic ch, input logic [AW-1:0] idx);
    return MEM_AW'(MEM_AW'(ch) * MEM_AW'(DELAY_LENGTH) + MEM_AW'(idx));
  endfunction

endpackage

// File: rtl/mdf_ram.sv
// ----------------------------------------------------------------------------
// mdf_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mdf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/mdf_mac.sv
// ----------------------------------------------------------------------------
// mdf_mac: shared multiply-accumulate unit
// Start from a rounding bias or add to the running sum, one product a cycle while enabled.
// ----------------------------------------------------------------------------
module mdf_mac
  import mdf_pkg::*;
(
  input  logic                    clk,
  input  mac_op_t                 op,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  base;

  assign prod = op.a * op.b;
  assign base = op.load ? $signed({{(ACC_W-BIAS_W){1'b0}}, op.bias}) : acc;

  always_ff @(posedge clk) begin
    if (op.en) begin
      acc <= base + $signed({{(ACC_W-PROD_W){prod[PROD_W-1]}}, prod});
    end
  end

endmodule

// File: rtl/mdf_cfg.sv
// ----------------------------------------------------------------------------
// mdf_cfg: configuration register file
// Write-only registers, taken at any edge with the write enable high and reset low.
// ----------------------------------------------------------------------------
module mdf_cfg
  import mdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data,
  output cfg_t              cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.centre_delay    <= '0;
      cfg.sweep_depth     <= '0;
      cfg.feedback_gain   <= '0;
      cfg.wet_mix         <= 16'd16384;
      cfg.active_channels <= 2'd2;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTRE_DELAY:    cfg.centre_delay    <= cfg_data;
        REG_SWEEP_DEPTH:     cfg.sweep_depth     <= cfg_data;
        REG_FEEDBACK_GAIN:   cfg.feedback_gain   <= cfg_data[15:0];
        REG_WET_MIX:         cfg.wet_mix         <= cfg_data[15:0];
        REG_ACTIVE_CHANNELS: cfg.active_channels <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/modulated_delay_flanger.sv
// ----------------------------------------------------------------------------
// modulated_delay_flanger: flanger with interpolated delay line and feedback
// Frame in (modulator plus one dry sample per channel), mixed frame out.
// ----------------------------------------------------------------------------
// Usage:
//   frame channel: frame_valid / frame_stall / frame. A request is taken at
//   an edge with frame_valid high and frame_stall low. The block holds
//   frame_stall high while a frame is in work, so one frame at a time.
//   result channel: result_valid / result_stall / result, same rule. The
//   result register parts the two sides: a new frame is taken while an
//   earlier result still waits.
//   cfg port: cfg_we / cfg_index / cfg_data, write only, no wait states.
//   Write registers only while the block is idle.
// Sequence: each frame runs through one shared multiply-accumulate unit under
//   the sequencer: first the delay (scale and clamp), then per active channel
//   two reads of the delay RAM, the MAC steps and a write, then the hand-over
//   of the result. A new frame is taken only after the last one is handed over.
// Reset: rst resets the sequencer, pointer, result_valid and configuration;
//   a clearing pass then zeroes all CHANNELS*DELAY_LENGTH (2048) RAM entries,
//   one a cycle, with frame_stall high. Configuration writes are taken throughout.
// Stall: with result_stall high the finished frame waits in the hand-over
//   state until the result register is free; nothing is dropped.
// ----------------------------------------------------------------------------
module modulated_delay_flanger
  import mdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              frame_valid,
  output logic              frame_stall,
  input  frame_t            frame,
  output logic              result_valid,
  input  logic              result_stall,
  output result_t           result,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [CFG_DW-1:0] cfg_data
);

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL_D,
    ST_CLAMP,
    ST_RD_A,
    ST_RD_B,
    ST_MAC_B,
    ST_DLY,
    ST_FB,
    ST_WR,
    ST_MIX,
    ST_OUT,
    ST_HOLD
  } state_t;

  state_t             state;
  cfg_t               cfg;
  frame_t             frame_reg;
  logic               ch;
  logic [MEM_AW-1:0]  clear_count;
  logic [AW-1:0]      wp;
  logic [AW-1:0]      rd_a;
  logic [AW-1:0]      rd_b;
  logic [7:0]         frac;
  logic signed [15:0] delayed;
  logic signed [15:0] res_left;
  logic signed [15:0] res_right;

  mac_op_t                 mac_op;
  logic signed [ACC_W-1:0] acc;

  logic              ram_we;
  logic [MEM_AW-1:0] ram_waddr;
  logic [15:0]       ram_wdata;
  logic [MEM_AW-1:0] ram_raddr;
  logic [15:0]       ram_rdata;

  logic signed [DW-1:0] d_raw;
  logic signed [DW-1:0] d_clamped;
  logic [AW-1:0]        n_int;
  logic [AW-1:0]        a_next;
  logic [AW-1:0]        b_next;
  logic [16:0]          wet;
  logic [1:0]           nch;
  logic                 chan_last;
  logic signed [15:0]   dry;
  logic signed [15:0]   fb_sample;
  logic signed [15:0]   mix_sample;

  mdf_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  mdf_mac u_mac (
    .clk (clk),
    .op  (mac_op),
    .acc (acc)
  );

  mdf_ram #(
    .WIDTH (16),
    .DEPTH (MEM_DEPTH)
  ) u_delay_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Delay: centre plus the scaled modulator, floor taken by the arithmetic
  // shift of the product; clamp to a tenth of a sample and to length minus two.
  always_comb begin
    d_raw = $signed(DW'({1'b0, cfg.centre_delay})) + DW'($signed(acc[ACC_W-1:15]));
    if (d_raw < $signed(DW'(DELAY_MIN))) begin
      d_clamped = DW'(DELAY_MIN);
    end else if (d_raw > $signed(DW'(DELAY_MAX))) begin
      d_clamped = DW'(DELAY_MAX);
    end else begin
      d_clamped = d_raw;
    end
    n_int  = d_clamped[AW+7:8];
    a_next = (wp >= n_int) ? AW'(wp - n_int) : AW'(wp - n_int + AW'(DELAY_LENGTH));
    b_next = (a_next == '0) ? AW'(DELAY_LENGTH - 1) : AW'(a_next - 1'b1);
  end

  // Wet above full acts as full; channel count zero acts as one, and the
  // count never goes past the channels built.
  assign wet = (cfg.wet_mix > 16'd32768) ? 17'd32768 : {1'b0, cfg.wet_mix};

  always_comb begin
    if (cfg.active_channels == 2'd0) begin
      nch = 2'd1;
    end else if (cfg.active_channels > 2'(CHANNELS)) begin
      nch = 2'(CHANNELS);
    end else begin
      nch = cfg.active_channels;
    end
  end

  assign chan_last  = ch || (nch == 2'd1);
  assign dry        = ch ? frame_reg.sample_right : frame_reg.sample_left;
  assign fb_sample  = sat16($signed({{5{dry[15]}}, dry}) + $signed(acc[35:15]));
  assign mix_sample = sat16($signed(acc[35:15]));

  // Drive the shared unit from the sequencer state.
  always_comb begin
    mac_op      = '0;
    mac_op.bias = BIAS_NONE;
    case (state)
      ST_MUL_D: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.a    = frame_reg.modulator_value;
        mac_op.b    = $signed({1'b0, cfg.sweep_depth});
      end
      ST_RD_B: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.bias = BIAS_Q8;
        mac_op.a    = $signed(ram_rdata);
        mac_op.b    = $signed(MAC_BW'(9'd256 - {1'b0, frac}));
      end
      ST_MAC_B: begin
        mac_op.en = 1'b1;
        mac_op.a  = $signed(ram_rdata);
        mac_op.b  = $signed(MAC_BW'(frac));
      end
      ST_FB: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.bias = BIAS_Q15;
        mac_op.a    = delayed;
        mac_op.b    = MAC_BW'(cfg.feedback_gain);
      end
      ST_WR: begin
        mac_op.en   = 1'b1;
        mac_op.load = 1'b1;
        mac_op.bias = BIAS_Q15;
        mac_op.a    = dry;
        mac_op.b    = $signed(MAC_BW'(18'd32768 - {1'b0, wet}));
      end
      ST_MIX: begin
        mac_op.en = 1'b1;
        mac_op.a  = delayed;
        mac_op.b  = $signed(MAC_BW'(wet));
      end
      default: ;
    endcase
  end

  // Delay RAM: zeroes during the clearing pass, feedback sample otherwise.
  always_comb begin
    ram_we    = (state == ST_CLEAR) || (state == ST_WR);
    ram_waddr = (state == ST_CLEAR) ? clear_count : mem_addr(ch, wp);
    ram_wdata = (state == ST_CLEAR) ? 16'd0 : fb_sample;
    ram_raddr = mem_addr(ch, (state == ST_RD_A) ? rd_a : rd_b);
  end

  assign frame_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clear_count  <= '0;
      wp           <= '0;
      ch           <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      // drop the result once taken; in the hand-over state the refill
      // below takes care of it
      if (result_valid && !result_stall && (state != ST_HOLD)) begin
        result_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clear_count <= MEM_AW'(clear_count + 1'b1);
          if (clear_count == MEM_AW'(MEM_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (frame_valid) begin
            frame_reg <= frame;
            res_right <= '0;
            ch        <= 1'b0;
            state     <= ST_MUL_D;
          end
        end
        ST_MUL_D: state <= ST_CLAMP;
        ST_CLAMP: begin
          rd_a  <= a_next;
          rd_b  <= b_next;
          frac  <= d_clamped[7:0];
          state <= ST_RD_A;
        end
        ST_RD_A:  state <= ST_RD_B;
        ST_RD_B:  state <= ST_MAC_B;
        ST_MAC_B: state <= ST_DLY;
        ST_DLY: begin
          // round half up already folded in by the bias
          delayed <= acc[23:8];
          state   <= ST_FB;
        end
        ST_FB:  state <= ST_WR;
        ST_WR:  state <= ST_MIX;
        ST_MIX: state <= ST_OUT;
        ST_OUT: begin
          if (ch) begin
            res_right <= mix_sample;
          end else begin
            res_left <= mix_sample;
          end
          if (chan_last) begin
            state <= ST_HOLD;
          end else begin
            ch    <= 1'b1;
            state <= ST_RD_A;
          end
        end
        ST_HOLD: begin
          // hold until the result register is free, then advance the pointer
          if (!result_valid || !result_stall) begin
            result.out_left  <= res_left;
            result.out_right <= res_right;
            result_valid     <= 1'b1;
            wp    <= (wp == AW'(DELAY_LENGTH - 1)) ? '0 : AW'(wp + 1'b1);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule
